@@ hdl/owrs_pkg.sv @@
// Package for the 1-Wire ROM search engine: opcode and status codes,
// the search state record and the per-transaction result record.
// No dependencies; imported by every module of the block.
package owrs_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_START = 2'd1,
    OP_PAIR  = 2'd2
  } owrs_op_e;

  typedef enum logic [2:0] {
    ST_CONTINUE = 3'd0,
    ST_FOUND    = 3'd1,
    ST_FAILED   = 3'd2,
    ST_WAS_LAST = 3'd3,
    ST_ACK      = 3'd4
  } owrs_status_e;

  // One past the highest bit position that may still record the family discrepancy.
  localparam logic [6:0] FamilyLimit = 7'd9;

  typedef struct packed {
    logic [63:0] rom_shadow;
    logic [6:0]  last_fork;
    logic [3:0]  family_fork;
    logic        last_found;
    logic [6:0]  bit_position;
    logic [6:0]  pass_last_zero;
    logic        pass_active;
  } owrs_state_t;

  localparam owrs_state_t StateReset = '{
    rom_shadow:     64'd0,
    last_fork:      7'd0,
    family_fork:    4'd0,
    last_found:     1'b0,
    bit_position:   7'd1,
    pass_last_zero: 7'd0,
    pass_active:    1'b0
  };

  typedef struct packed {
    owrs_status_e status;
    logic         write_valid;
    logic         direction;
    logic [63:0]  rom_code;
    logic [3:0]   family_point;
    logic         last_device;
  } owrs_result_t;

endpackage

@@ hdl/owrs_step.sv @@
// Combinational decision step of the 1-Wire ROM search engine.
// Maps one transaction and the current search state to the next state and
// one result. Depends on owrs_pkg.
module owrs_step import owrs_pkg::*; #(
  parameter int ROM_BYTES = 8
) (
  input  logic [1:0]   opcode_i,
  input  logic         presence_i,
  input  logic         id_bit_i,
  input  logic         complement_bit_i,
  input  owrs_state_t  state_i,
  output owrs_state_t  state_o,
  output owrs_result_t result_o
);

  localparam logic [6:0] TotalBits = 7'(8 * ROM_BYTES);

  logic [6:0]  pos;
  logic [5:0]  idx;
  logic        dir;
  logic [63:0] rom_next;
  logic [6:0]  last_zero_next;
  logic [3:0]  family_next;

  // Position clamped to 1..64; index of the ROM bit it addresses.
  always_comb begin
    pos = state_i.bit_position;
    if (pos == 7'd0) begin
      pos = 7'd1;
    end else if (pos > 7'd64) begin
      pos = 7'd64;
    end
    idx = 6'(pos - 7'd1);
  end

  // Direction choice and the shadow and discrepancy values it leads to.
  always_comb begin
    last_zero_next = state_i.pass_last_zero;
    family_next    = state_i.family_fork;
    if (id_bit_i != complement_bit_i) begin
      dir = id_bit_i;
    end else begin
      if (pos < state_i.last_fork) begin
        dir = state_i.rom_shadow[idx];
      end else begin
        dir = (pos == state_i.last_fork);
      end
      if (!dir) begin
        last_zero_next = pos;
        if (pos < FamilyLimit) begin
          family_next = pos[3:0];
        end
      end
    end
    rom_next      = state_i.rom_shadow;
    rom_next[idx] = dir;
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{status: ST_ACK, write_valid: 1'b0, direction: 1'b0,
                 rom_code: 64'd0, family_point: 4'd0, last_device: 1'b0};
    unique case (opcode_i)
      OP_CLEAR: begin
        state_o = StateReset;
      end
      OP_START: begin
        state_o.pass_active = 1'b0;
        if (state_i.last_found) begin
          state_o.last_fork   = 7'd0;
          state_o.family_fork = 4'd0;
          state_o.last_found  = 1'b0;
          result_o.status     = ST_WAS_LAST;
        end else if (!presence_i) begin
          state_o.last_fork   = 7'd0;
          state_o.family_fork = 4'd0;
          state_o.last_found  = 1'b0;
          result_o.status     = ST_FAILED;
        end else begin
          state_o.pass_active    = 1'b1;
          state_o.bit_position   = 7'd1;
          state_o.pass_last_zero = 7'd0;
          result_o.status        = ST_CONTINUE;
        end
      end
      OP_PAIR: begin
        if (state_i.pass_active) begin
          if (id_bit_i && complement_bit_i) begin
            // No device answered this slot: abandon the pass.
            state_o.last_fork   = 7'd0;
            state_o.family_fork = 4'd0;
            state_o.last_found  = 1'b0;
            state_o.pass_active = 1'b0;
            result_o.status     = ST_FAILED;
          end else begin
            state_o.rom_shadow     = rom_next;
            state_o.pass_last_zero = last_zero_next;
            state_o.family_fork    = family_next;
            state_o.bit_position   = pos + 7'd1;
            result_o.write_valid   = 1'b1;
            result_o.direction     = dir;
            result_o.status        = ST_CONTINUE;
            if (pos >= TotalBits) begin
              state_o.pass_active = 1'b0;
              state_o.last_fork   = last_zero_next;
              if (last_zero_next == 7'd0) begin
                state_o.last_found = 1'b1;
              end
              if (rom_next[7:0] == 8'd0) begin
                // A zero family byte cannot be a real device.
                state_o.last_fork   = 7'd0;
                state_o.family_fork = 4'd0;
                state_o.last_found  = 1'b0;
                result_o.status     = ST_FAILED;
              end else begin
                result_o.status       = ST_FOUND;
                result_o.rom_code     = rom_next;
                result_o.family_point = family_next;
                result_o.last_device  = state_o.last_found;
              end
            end
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

@@ hdl/one_wire_rom_search.sv @@
// Top level of the 1-Wire ROM search decision engine.
// Holds the input register, the search state and the result register;
// depends on owrs_pkg and owrs_step.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o  | opcode, presence, id/compl bit
//   out     | output    | out_valid_o / out_stall_i| status, write_valid, direction,
//           |           |                          | rom_code, family_point, last_dev
//
// Every transaction yields exactly one result. A transaction is captured in
// the input register, evaluated there against the search state, and its
// result lands in the output register at the same edge that updates the
// state. One transaction is taken per cycle for as long as the output side
// is not stalling.
// Reset is asynchronous and active low; it returns the search state to its
// idle values and empties both registers.
// A stall on the output holds the result register, and the input register
// then holds its transaction and raises in_stall_o in the same cycle.
module one_wire_rom_search import owrs_pkg::*; #(
  parameter int ROM_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic        presence_i,
  input  logic        id_bit_i,
  input  logic        complement_bit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        write_valid_o,
  output logic        direction_o,
  output logic [63:0] rom_code_o,
  output logic [3:0]  family_point_o,
  output logic        last_device_o
);

  // Input register: valid bit plus the raw transaction fields.
  logic       in_valid_q;
  logic [1:0] opcode_q;
  logic       presence_q;
  logic       id_bit_q;
  logic       complement_bit_q;

  // Search state, updated only when a transaction moves into the result.
  owrs_state_t state_q, state_d;

  // Result register.
  logic         out_valid_q;
  owrs_result_t result_q, result_d;

  logic advance;
  logic in_accept;

  // The evaluated transaction leaves the input register whenever the result
  // register is empty or is being drained in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  owrs_step #(
    .ROM_BYTES (ROM_BYTES)
  ) u_step (
    .opcode_i         (opcode_q),
    .presence_i       (presence_q),
    .id_bit_i         (id_bit_q),
    .complement_bit_i (complement_bit_q),
    .state_i          (state_q),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q         <= opcode_i;
      presence_q       <= presence_i;
      id_bit_q         <= id_bit_i;
      complement_bit_q <= complement_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = result_q.status;
  assign write_valid_o  = result_q.write_valid;
  assign direction_o    = result_q.direction;
  assign rom_code_o     = result_q.rom_code;
  assign family_point_o = result_q.family_point;
  assign last_device_o  = result_q.last_device;

endmodule

@@ hdl/owrs_checker.sv @@
// Port-level checker for the 1-Wire ROM search engine, bound to the top.
// Depends on owrs_pkg for the status codes.
module owrs_checker import owrs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic        write_valid_o,
  input logic        direction_o,
  input logic [63:0] rom_code_o,
  input logic [3:0]  family_point_o,
  input logic        last_device_o
);

  // A stalled result stays on the port with its code unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed or dropped");

  // A direction bit is only ever written on a continue, found or failed result.
  a_write_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |->
      (status_o == ST_CONTINUE || status_o == ST_FOUND || status_o == ST_FAILED))
    else $error("write requested on an acknowledge result");

  a_dir_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && direction_o |-> write_valid_o)
    else $error("direction set without a write");

  // Device details appear only with a found device.
  a_found_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FOUND) |->
      rom_code_o == 64'd0 && family_point_o == 4'd0 && !last_device_o)
    else $error("device fields set without a found device");

  // A found device always has a nonzero family byte and a family point in range.
  a_found_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FOUND) |->
      rom_code_o[7:0] != 8'd0 && family_point_o <= 4'd8 && write_valid_o)
    else $error("found result with an impossible code");

endmodule

bind one_wire_rom_search owrs_checker u_owrs_checker (.*);
